@@ rtl/jpt_pkg.sv @@
// Shared types and constants for the joint PD torque unit.
`default_nettype none

package jpt_pkg;

	localparam int unsigned IDX_W    = 6;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned GAIN_W   = 31;
	localparam int unsigned DT_W     = 16;
	localparam int unsigned CFG_W    = 31;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STABLE_MODE = 3'd0,
		REG_TORQUE_LIMIT = 3'd1,
		REG_POSITION_GAIN = 3'd2,
		REG_VELOCITY_GAIN = 3'd3,
		REG_TIME_STEP = 3'd4,
		REG_VEL_WARN_LEVEL = 3'd5
	} jpt_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         joint;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] acc;
		logic signed [DATA_W-1:0] tpos;
		logic signed [DATA_W-1:0] tvel;
	} jpt_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] joint;
		logic             root;
		logic             warn;
	} jpt_tag_t;

	typedef struct packed {
		jpt_item_t item;
		logic      root;
		logic      warn;
	} jpt_qent_t;

	typedef struct packed {
		logic              stable_mode;
		logic [GAIN_W-1:0] torque_limit;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] kd;
		logic [DT_W-1:0]   dt;
	} jpt_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/jpt_front.sv @@
// Input stage: registers one joint sample and classifies it (root joint, velocity warning).
`default_nettype none

module jpt_front #(
	parameter int unsigned ROOT_DOFS = 6
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  jpt_pkg::jpt_item_t        in_item,
	input  wire [jpt_pkg::GAIN_W-1:0] warn_level,
	output logic                      push_valid,
	input  wire                       push_stall,
	output jpt_pkg::jpt_qent_t        push_data
);
	import jpt_pkg::*;

	localparam logic [IDX_W-1:0] ROOT_LIM = IDX_W'(ROOT_DOFS);

	logic                valid_s1;
	jpt_item_t           item_s1;
	logic                load;
	logic [DATA_W-1:0]   vmag;

	assign in_stall = valid_s1 && push_stall;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

	// Magnitude of the most negative velocity still fits as unsigned
	assign vmag = item_s1.vel[DATA_W-1] ? (~item_s1.vel + 1'b1) : item_s1.vel;

	assign push_valid     = valid_s1;
	assign push_data.item = item_s1;
	assign push_data.root = item_s1.joint < ROOT_LIM;
	assign push_data.warn = vmag >= {1'b0, warn_level};

endmodule

`default_nettype wire

@@ rtl/jpt_queue.sv @@
// Short register queue between the classifying front and the arithmetic back end.
`default_nettype none

module jpt_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_stall,
	input  jpt_pkg::jpt_qent_t push_data,
	output logic               pop_valid,
	input  wire                pop_stall,
	output jpt_pkg::jpt_qent_t pop_data
);
	import jpt_pkg::*;

	jpt_qent_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_stall = count_q == (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/jpt_back.sv @@
// Arithmetic pipeline: lookahead, error terms, split gain products, sum and clamp.
`default_nettype none

module jpt_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            pop_valid,
	output logic                           pop_stall,
	input  jpt_pkg::jpt_qent_t             pop_data,
	input  jpt_pkg::jpt_ctrl_t             ctrl,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [jpt_pkg::IDX_W-1:0]      joint_out,
	output logic signed [jpt_pkg::DATA_W-1:0] torque,
	output logic                           clamped,
	output logic                           velocity_warning
);
	import jpt_pkg::*;

	// Stage valids and bubble-collapsing advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5      = !v_s5 || !out_stall;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pop_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pop_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: lookahead products dt*vel and dt*acc
	logic [DT_W-1:0]          dt_eff;
	logic signed [DT_W:0]     dt_sg;
	logic signed [48:0]       dp_c, dv_c;
	jpt_tag_t                 tag_s1;
	logic signed [DATA_W-1:0] pos_s1, vel_s1, tpos_s1, tvel_s1;
	logic signed [48:0]       dp_s1, dv_s1;

	assign dt_eff = ctrl.stable_mode ? ctrl.dt : '0;
	assign dt_sg  = $signed({1'b0, dt_eff});
	assign dp_c   = dt_sg * pop_data.item.vel;
	assign dv_c   = dt_sg * pop_data.item.acc;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			tag_s1  <= '{joint: pop_data.item.joint, root: pop_data.root, warn: pop_data.warn};
			pos_s1  <= pop_data.item.pos;
			vel_s1  <= pop_data.item.vel;
			tpos_s1 <= pop_data.item.tpos;
			tvel_s1 <= pop_data.item.tvel;
			dp_s1   <= dp_c;
			dv_s1   <= dv_c;
		end
	end

	// Stage 2: errors, exact in 34 bits
	logic [33:0] ep_c, ev_c;
	jpt_tag_t    tag_s2;
	logic [33:0] ep_s2, ev_s2;

	assign ep_c = {{2{tpos_s1[DATA_W-1]}}, tpos_s1} - {{2{pos_s1[DATA_W-1]}}, pos_s1}
		- {dp_s1[48], dp_s1[48:16]};
	assign ev_c = {{2{tvel_s1[DATA_W-1]}}, tvel_s1} - {{2{vel_s1[DATA_W-1]}}, vel_s1}
		- {dv_s1[48], dv_s1[48:16]};

	always_ff @(posedge clk) begin
		if (rdy2) begin
			tag_s2 <= tag_s1;
			ep_s2  <= ep_c;
			ev_s2  <= ev_c;
		end
	end

	// Stage 3: gain times error, split into low 17 bits and signed high part
	logic signed [GAIN_W:0] kp_sg, kd_sg;
	logic signed [49:0]     pplo_c, pvlo_c;
	logic signed [48:0]     pphi_c, pvhi_c;
	jpt_tag_t               tag_s3;
	logic signed [49:0]     pplo_s3, pvlo_s3;
	logic signed [48:0]     pphi_s3, pvhi_s3;

	assign kp_sg  = $signed({1'b0, ctrl.kp});
	assign kd_sg  = $signed({1'b0, ctrl.kd});
	assign pplo_c = kp_sg * $signed({1'b0, ep_s2[16:0]});
	assign pvlo_c = kd_sg * $signed({1'b0, ev_s2[16:0]});
	assign pphi_c = kp_sg * $signed(ep_s2[33:17]);
	assign pvhi_c = kd_sg * $signed(ev_s2[33:17]);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			tag_s3  <= tag_s2;
			pplo_s3 <= pplo_c;
			pvlo_s3 <= pvlo_c;
			pphi_s3 <= pphi_c;
			pvhi_s3 <= pvhi_c;
		end
	end

	// Stage 4: recombine partial products and drop 16 fraction bits (floor)
	logic [65:0]        pfull_c, vfull_c;
	jpt_tag_t           tag_s4;
	logic signed [49:0] tp_s4, tv_s4;

	assign pfull_c = {pphi_s3, 17'b0} + {16'b0, pplo_s3};
	assign vfull_c = {pvhi_s3, 17'b0} + {16'b0, pvlo_s3};

	always_ff @(posedge clk) begin
		if (rdy4) begin
			tag_s4 <= tag_s3;
			tp_s4  <= $signed(pfull_c[65:16]);
			tv_s4  <= $signed(vfull_c[65:16]);
		end
	end

	// Stage 5: sum, clamp, force root joints to zero
	logic signed [50:0]       sum_c;
	logic signed [50:0]       lim_c;
	logic                     over_hi, over_lo;
	logic [DATA_W-1:0]        lim32;
	logic [DATA_W-1:0]        tq_c;
	logic [IDX_W-1:0]         joint_s5;
	logic signed [DATA_W-1:0] torque_s5;
	logic                     clamped_s5;
	logic                     warn_s5;

	assign sum_c   = {tp_s4[49], tp_s4} + {tv_s4[49], tv_s4};
	assign lim_c   = $signed({20'b0, ctrl.torque_limit});
	assign over_hi = sum_c > lim_c;
	assign over_lo = sum_c < -lim_c;
	assign lim32   = {1'b0, ctrl.torque_limit};

	always_comb begin
		if (over_hi) begin
			tq_c = lim32;
		end else if (over_lo) begin
			tq_c = ~lim32 + 1'b1;
		end else begin
			tq_c = sum_c[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			joint_s5   <= tag_s4.joint;
			torque_s5  <= tag_s4.root ? '0 : $signed(tq_c);
			clamped_s5 <= !tag_s4.root && (over_hi || over_lo);
			warn_s5    <= tag_s4.warn;
		end
	end

	assign out_valid        = v_s5;
	assign joint_out        = joint_s5;
	assign torque           = torque_s5;
	assign clamped          = clamped_s5;
	assign velocity_warning = warn_s5;

endmodule

`default_nettype wire

@@ rtl/joint_pd_torque.sv @@
// Joint torque unit: PD or stable-PD law with clamp, root-joint zeroing and velocity warning.
// Path from input transfer to out_valid: input register, queue, five arithmetic stages
// ending in the output register. Throughput: one joint per cycle while out_stall is low,
// set by the fully pipelined back end and the 4-entry queue.
// Reset: asynchronous, active low; clears all valids and the queue, loads register defaults.
`default_nettype none

module joint_pd_torque #(
	parameter int unsigned ROOT_DOFS = 6
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire [jpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [jpt_pkg::CFG_W-1:0]         cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [jpt_pkg::IDX_W-1:0]         joint_index,
	input  wire signed [jpt_pkg::DATA_W-1:0] position,
	input  wire signed [jpt_pkg::DATA_W-1:0] velocity,
	input  wire signed [jpt_pkg::DATA_W-1:0] acceleration,
	input  wire signed [jpt_pkg::DATA_W-1:0] target_position,
	input  wire signed [jpt_pkg::DATA_W-1:0] target_velocity,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [jpt_pkg::IDX_W-1:0]        joint_out,
	output logic signed [jpt_pkg::DATA_W-1:0] torque,
	output logic                             clamped,
	output logic                             velocity_warning
);
	import jpt_pkg::*;

	logic              stable_mode_q;
	logic [GAIN_W-1:0] torque_limit_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] kd_q;
	logic [DT_W-1:0]   dt_q;
	logic [GAIN_W-1:0] warn_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_mode_q  <= 1'b0;
			torque_limit_q <= '1;
			kp_q           <= '0;
			kd_q           <= '0;
			dt_q           <= '0;
			warn_level_q   <= '1;
		end else if (cfg_wr_en) begin
			case (jpt_reg_t'(cfg_index))
				REG_STABLE_MODE:    stable_mode_q  <= cfg_data[0];
				REG_TORQUE_LIMIT:   torque_limit_q <= cfg_data[GAIN_W-1:0];
				REG_POSITION_GAIN:  kp_q           <= cfg_data[GAIN_W-1:0];
				REG_VELOCITY_GAIN:  kd_q           <= cfg_data[GAIN_W-1:0];
				REG_TIME_STEP:      dt_q           <= cfg_data[DT_W-1:0];
				REG_VEL_WARN_LEVEL: warn_level_q   <= cfg_data[GAIN_W-1:0];
				default:            ;
			endcase
		end
	end

	jpt_item_t in_item;
	jpt_qent_t push_data, pop_data;
	jpt_ctrl_t ctrl;
	logic      push_valid, push_stall, pop_valid, pop_stall;

	assign in_item.joint = joint_index;
	assign in_item.pos   = position;
	assign in_item.vel   = velocity;
	assign in_item.acc   = acceleration;
	assign in_item.tpos  = target_position;
	assign in_item.tvel  = target_velocity;

	assign ctrl.stable_mode  = stable_mode_q;
	assign ctrl.torque_limit = torque_limit_q;
	assign ctrl.kp           = kp_q;
	assign ctrl.kd           = kd_q;
	assign ctrl.dt           = dt_q;

	jpt_front #(
		.ROOT_DOFS(ROOT_DOFS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.warn_level (warn_level_q),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	jpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data)
	);

	jpt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop_stall        (pop_stall),
		.pop_data         (pop_data),
		.ctrl             (ctrl),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.joint_out        (joint_out),
		.torque           (torque),
		.clamped          (clamped),
		.velocity_warning (velocity_warning)
	);

endmodule

`default_nettype wire
